@@ rtl/header_comp_state_decider_macros.svh @@
// Assertion macros for the header compressor state decider.
// Both macros sample on posedge clk; the first is disabled during rst.
`ifndef HEADER_COMP_STATE_DECIDER_MACROS_SVH
`define HEADER_COMP_STATE_DECIDER_MACROS_SVH
`ifndef ASSERT_OFF
`define HCSD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hcsd assertion failed");
`define HCSD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hcsd assertion failed");
`else
`define HCSD_ASSERT(label, prop)
`define HCSD_ASSERT_ALWAYS(label, prop)
`endif
`endif

@@ rtl/hcsd_pkg.sv @@
package hcsd_pkg;

  typedef enum logic [2:0] {
    ST_IR = 3'b001,
    ST_FO = 3'b010,
    ST_SO = 3'b100
  } comp_st_t;

  localparam logic [1:0] CODE_IR = 2'd0;
  localparam logic [1:0] CODE_FO = 2'd1;
  localparam logic [1:0] CODE_SO = 2'd2;

  localparam logic [2:0] CAUSE_NONE    = 3'd0;
  localparam logic [2:0] CAUSE_IR_PKT  = 3'd1;
  localparam logic [2:0] CAUSE_IR_TIME = 3'd2;
  localparam logic [2:0] CAUSE_FO_PKT  = 3'd3;
  localparam logic [2:0] CAUSE_FO_TIME = 3'd4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNI_MODE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIME_EN     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IR_REF_PKTS = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FO_REF_PKTS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_IR_REF_TIME = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_FO_REF_TIME = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_IR_REPEAT   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_FO_REPEAT   = 3'd7;

  typedef struct packed {
    logic [31:0] sec;
    logic [29:0] nsec;
  } pkt_t;

  typedef struct packed {
    logic [1:0] comp_state;
    logic       state_changed;
    logic [2:0] refresh_cause;
  } res_t;

  typedef struct packed {
    logic write;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_wr_t;

endpackage

@@ rtl/hcsd_pkt_queue.sv @@
module hcsd_pkt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hcsd_pkg::pkt_t push_data,
  output logic          full,
  input  logic          pop,
  output hcsd_pkg::pkt_t pop_data,
  output logic          empty
);

  hcsd_pkg::pkt_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/hcsd_res_queue.sv @@
module hcsd_res_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hcsd_pkg::res_t push_data,
  output logic          full,
  input  logic          pop,
  output hcsd_pkg::res_t pop_data,
  output logic          empty
);

  hcsd_pkg::res_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/hcsd_decider.sv @@
`include "header_comp_state_decider_macros.svh"

module hcsd_decider (
  input  logic            clk,
  input  logic            rst,
  input  hcsd_pkg::cfg_wr_t cfg,
  input  logic            pkt_valid,
  input  hcsd_pkg::pkt_t  pkt,
  output logic            pkt_take,
  output logic            res_valid,
  output hcsd_pkg::res_t  res,
  input  logic            res_full
);

  logic        uni_mode;
  logic        time_en;
  logic [15:0] ir_ref_pkts;
  logic [15:0] fo_ref_pkts;
  logic [15:0] ir_ref_time;
  logic [15:0] fo_ref_time;
  logic [7:0]  ir_repeat;
  logic [7:0]  fo_repeat;

  hcsd_pkg::comp_st_t state;
  logic [7:0]  ir_sent;
  logic [7:0]  fo_sent;
  logic [31:0] ir_ref_cnt;
  logic [31:0] fo_ref_cnt;
  logic [31:0] ir_stamp_sec;
  logic [29:0] ir_stamp_nsec;
  logic [31:0] fo_stamp_sec;
  logic [29:0] fo_stamp_nsec;

  hcsd_pkg::comp_st_t state_next;
  hcsd_pkg::comp_st_t st_a;
  logic [7:0]  ir_sent_next;
  logic [7:0]  fo_sent_next;
  logic [7:0]  ir_sent_a;
  logic [7:0]  fo_sent_a;
  logic [7:0]  ir_sent_b;
  logic [7:0]  fo_sent_b;
  logic [31:0] ir_ref_cnt_next;
  logic [31:0] fo_ref_cnt_next;
  logic        clr_ir;
  logic        clr_fo;
  logic        ir_to;
  logic        fo_to;
  logic [2:0]  cause;
  logic [1:0]  code;
  logic        go;

  function automatic logic timed_out(
    input logic [31:0] s1,
    input logic [29:0] n1,
    input logic [31:0] s0,
    input logic [29:0] n0,
    input logic [15:0] limit
  );
    logic [63:0] ds;
    logic [63:0] d;
    ds = {32'd0, s1} - {32'd0, s0};
    d  = {ds[33:0], 30'd0} + {34'd0, n1} - {34'd0, n0};
    return d[63:10] >= {28'd0, limit, 10'd0};
  endfunction

  assign go       = pkt_valid && !res_full;
  assign pkt_take = go;

  always_comb begin
    ir_to = timed_out(pkt.sec, pkt.nsec, ir_stamp_sec, ir_stamp_nsec, ir_ref_time);
    fo_to = timed_out(pkt.sec, pkt.nsec, fo_stamp_sec, fo_stamp_nsec, fo_ref_time);

    case (state)
      hcsd_pkg::ST_IR: st_a = (ir_sent < ir_repeat) ? hcsd_pkg::ST_IR : hcsd_pkg::ST_SO;
      hcsd_pkg::ST_FO: st_a = (fo_sent < fo_repeat) ? hcsd_pkg::ST_FO : hcsd_pkg::ST_SO;
      default:         st_a = hcsd_pkg::ST_SO;
    endcase
    ir_sent_a = (st_a != state) ? 8'd0 : ir_sent;
    fo_sent_a = (st_a != state) ? 8'd0 : fo_sent;

    state_next = st_a;
    cause      = hcsd_pkg::CAUSE_NONE;
    clr_ir     = 1'b0;
    clr_fo     = 1'b0;
    if (uni_mode) begin
      if (ir_ref_cnt >= {16'd0, ir_ref_pkts}) begin
        clr_ir     = 1'b1;
        state_next = hcsd_pkg::ST_IR;
        cause      = hcsd_pkg::CAUSE_IR_PKT;
      end else if (time_en && ir_to) begin
        clr_ir     = 1'b1;
        state_next = hcsd_pkg::ST_IR;
        cause      = hcsd_pkg::CAUSE_IR_TIME;
      end else if (fo_ref_cnt >= {16'd0, fo_ref_pkts}) begin
        clr_fo     = 1'b1;
        state_next = hcsd_pkg::ST_FO;
        cause      = hcsd_pkg::CAUSE_FO_PKT;
      end else if (time_en && fo_to) begin
        clr_fo     = 1'b1;
        state_next = hcsd_pkg::ST_FO;
        cause      = hcsd_pkg::CAUSE_FO_TIME;
      end
    end
    ir_sent_b = (state_next != st_a) ? 8'd0 : ir_sent_a;
    fo_sent_b = (state_next != st_a) ? 8'd0 : fo_sent_a;

    ir_ref_cnt_next = clr_ir ? 32'd0 : ir_ref_cnt;
    fo_ref_cnt_next = clr_fo ? 32'd0 : fo_ref_cnt;
    if (state_next != hcsd_pkg::ST_IR) begin
      ir_ref_cnt_next = ir_ref_cnt_next + 32'd1;
    end
    if (state_next == hcsd_pkg::ST_SO) begin
      fo_ref_cnt_next = fo_ref_cnt_next + 32'd1;
    end

    ir_sent_next = ir_sent_b;
    fo_sent_next = fo_sent_b;
    if (state_next == hcsd_pkg::ST_IR && ir_sent_b != 8'hFF) begin
      ir_sent_next = ir_sent_b + 8'd1;
    end
    if (state_next == hcsd_pkg::ST_FO && fo_sent_b != 8'hFF) begin
      fo_sent_next = fo_sent_b + 8'd1;
    end

    case (state_next)
      hcsd_pkg::ST_IR: code = hcsd_pkg::CODE_IR;
      hcsd_pkg::ST_FO: code = hcsd_pkg::CODE_FO;
      default:         code = hcsd_pkg::CODE_SO;
    endcase
  end

  assign res_valid         = go;
  assign res.comp_state    = code;
  assign res.state_changed = (state_next != state);
  assign res.refresh_cause = cause;

  always_ff @(posedge clk) begin
    if (rst) begin
      uni_mode    <= 1'b1;
      time_en     <= 1'b0;
      ir_ref_pkts <= 16'd1700;
      fo_ref_pkts <= 16'd700;
      ir_ref_time <= 16'd1000;
      fo_ref_time <= 16'd500;
      ir_repeat   <= 8'd3;
      fo_repeat   <= 8'd3;
    end else if (cfg.write) begin
      case (cfg.index)
        hcsd_pkg::CFG_UNI_MODE:    uni_mode    <= cfg.data[0];
        hcsd_pkg::CFG_TIME_EN:     time_en     <= cfg.data[0];
        hcsd_pkg::CFG_IR_REF_PKTS: ir_ref_pkts <= cfg.data;
        hcsd_pkg::CFG_FO_REF_PKTS: fo_ref_pkts <= cfg.data;
        hcsd_pkg::CFG_IR_REF_TIME: ir_ref_time <= cfg.data;
        hcsd_pkg::CFG_FO_REF_TIME: fo_ref_time <= cfg.data;
        hcsd_pkg::CFG_IR_REPEAT:   ir_repeat   <= cfg.data[7:0];
        hcsd_pkg::CFG_FO_REPEAT:   fo_repeat   <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= hcsd_pkg::ST_IR;
      ir_sent       <= 8'd0;
      fo_sent       <= 8'd0;
      ir_ref_cnt    <= 32'd0;
      fo_ref_cnt    <= 32'd0;
      ir_stamp_sec  <= 32'd0;
      ir_stamp_nsec <= 30'd0;
      fo_stamp_sec  <= 32'd0;
      fo_stamp_nsec <= 30'd0;
    end else if (go) begin
      state   <= state_next;
      ir_sent <= ir_sent_next;
      fo_sent <= fo_sent_next;
      if (uni_mode) begin
        ir_ref_cnt <= ir_ref_cnt_next;
        fo_ref_cnt <= fo_ref_cnt_next;
        if (state_next == hcsd_pkg::ST_IR) begin
          ir_stamp_sec  <= pkt.sec;
          ir_stamp_nsec <= pkt.nsec;
        end
        if (state_next == hcsd_pkg::ST_IR || state_next == hcsd_pkg::ST_FO) begin
          fo_stamp_sec  <= pkt.sec;
          fo_stamp_nsec <= pkt.nsec;
        end
      end
    end
  end

  `HCSD_ASSERT_ALWAYS(a_reset_to_ir, $past(rst) |-> state == hcsd_pkg::ST_IR)
  `HCSD_ASSERT(a_cause_needs_umode, go && cause != hcsd_pkg::CAUSE_NONE |-> uni_mode)
  `HCSD_ASSERT(a_ir_cause_state,
    go && (cause == hcsd_pkg::CAUSE_IR_PKT || cause == hcsd_pkg::CAUSE_IR_TIME)
    |-> code == hcsd_pkg::CODE_IR)
  `HCSD_ASSERT(a_fo_cause_state,
    go && (cause == hcsd_pkg::CAUSE_FO_PKT || cause == hcsd_pkg::CAUSE_FO_TIME)
    |-> code == hcsd_pkg::CODE_FO)
  `HCSD_ASSERT(a_ir_count_cleared,
    go && uni_mode && (cause == hcsd_pkg::CAUSE_IR_PKT || cause == hcsd_pkg::CAUSE_IR_TIME)
    |=> ir_ref_cnt == 32'd0)

endmodule

@@ rtl/header_comp_state_decider.sv @@
// Header compressor state decider (IR / FO / SO), one decision per packet.
// Input channel: present pkt_seconds/pkt_nanoseconds with push; the packet
//   transaction completes on a clock edge where push is high and full is low.
// Result channel: while empty is low the oldest decision is on comp_state,
//   state_changed and refresh_cause; pop with empty low takes it.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
//   on the same edge; write only while no packet is in flight.
// Throughput: one packet per cycle while the result queue has room, set by
//   the decision step, which is combinational (count compares and two
//   64-bit elapsed-time subtract/compares).
// Two-entry queues sit before and after the decision step; when pop is held
//   low the result queue fills, the decision step holds, and full rises once
//   the input queue also holds two packets. Nothing is dropped.
// Reset (rst, synchronous): queues empty, state IR, all counts and stamps
//   zero, registers at their default values.
module header_comp_state_decider (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] pkt_seconds,
  input  logic [29:0] pkt_nanoseconds,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  comp_state,
  output logic        state_changed,
  output logic [2:0]  refresh_cause,
  input  logic        cfg_write,
  input  logic [hcsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hcsd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  hcsd_pkg::pkt_t    in_pkt;
  hcsd_pkg::pkt_t    q_pkt;
  hcsd_pkg::res_t    dec_res;
  hcsd_pkg::res_t    out_res;
  hcsd_pkg::cfg_wr_t cfg;
  logic              q_empty;
  logic              pkt_take;
  logic              res_valid;
  logic              res_full;

  assign in_pkt.sec  = pkt_seconds;
  assign in_pkt.nsec = pkt_nanoseconds;
  assign cfg.write   = cfg_write;
  assign cfg.index   = cfg_index;
  assign cfg.data    = cfg_data;

  hcsd_pkt_queue u_in_q (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (in_pkt),
    .full      (full),
    .pop       (pkt_take),
    .pop_data  (q_pkt),
    .empty     (q_empty)
  );

  hcsd_decider u_dec (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pkt_valid (!q_empty),
    .pkt       (q_pkt),
    .pkt_take  (pkt_take),
    .res_valid (res_valid),
    .res       (dec_res),
    .res_full  (res_full)
  );

  hcsd_res_queue u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (dec_res),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (out_res),
    .empty     (empty)
  );

  assign comp_state    = out_res.comp_state;
  assign state_changed = out_res.state_changed;
  assign refresh_cause = out_res.refresh_cause;

endmodule
